// ----- src/iso2ep_pkg.sv -----
package iso2ep_pkg;

	localparam int unsigned TS_LENGTH = 19;
	localparam int unsigned YEAR_MIN  = 1970;
	localparam int unsigned YEAR_MAX  = 2100;
	localparam int unsigned MQ_DEPTH  = 4;
	localparam int unsigned MQ_AW     = $clog2(MQ_DEPTH);
	localparam int unsigned OQ_DEPTH  = 8;
	localparam int unsigned OQ_AW     = $clog2(OQ_DEPTH);

	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// year 2100 is the one year in range with year % 4 == 0 that is not leap
	localparam logic [7:0] YOFF_2100 = 8'(YEAR_MAX - YEAR_MIN);

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] epoch_seconds;
	} out_item_t;

	// one parsed text, fields already narrowed to their checked ranges
	typedef struct packed {
		logic       ok;
		logic [7:0] yoff;
		logic [3:0] month_idx;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} rec_t;

	function automatic logic [8:0] month_start(input logic [3:0] idx);
		case (idx)
			4'd0:    month_start = 9'd0;
			4'd1:    month_start = 9'd31;
			4'd2:    month_start = 9'd59;
			4'd3:    month_start = 9'd90;
			4'd4:    month_start = 9'd120;
			4'd5:    month_start = 9'd151;
			4'd6:    month_start = 9'd181;
			4'd7:    month_start = 9'd212;
			4'd8:    month_start = 9'd243;
			4'd9:    month_start = 9'd273;
			4'd10:   month_start = 9'd304;
			4'd11:   month_start = 9'd334;
			default: month_start = 9'd0;
		endcase
	endfunction

endpackage

// ----- src/iso2ep_front.sv -----
module iso2ep_front import iso2ep_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     rec_push,
	output rec_t     rec
);

	logic [4:0]  pos_q, pos_n;
	logic        err_q, err_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  month_q, month_n, day_q, day_n, hour_q, hour_n;
	logic [6:0]  minute_q, minute_n, second_q, second_n;
	logic        digit;
	logic [3:0]  d;
	logic [7:0]  c;

	function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] dg);
		acc14 = {a[10:0], 3'b000} + {a[12:0], 1'b0} + {10'd0, dg};
	endfunction

	function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] dg);
		acc7 = {a[3:0], 3'b000} + {a[5:0], 1'b0} + {3'd0, dg};
	endfunction

	assign c     = item.char_code;
	assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign d     = digit ? 4'(c - CH_ZERO) : 4'd0;

	always_comb begin
		pos_n    = pos_q;
		err_n    = err_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		if (pos_q < 5'(TS_LENGTH)) begin
			pos_n = pos_q + 5'd1;
			case (pos_q) inside
				5'd4, 5'd7:   if (c != CH_DASH) err_n = 1'b1;
				5'd10:        if (c != CH_T) err_n = 1'b1;
				5'd13, 5'd16: if (c != CH_COLON) err_n = 1'b1;
				default: begin
					if (!digit) begin
						err_n = 1'b1;
					end else begin
						case (pos_q) inside
							[5'd0:5'd3]:   year_n   = acc14(year_q, d);
							[5'd5:5'd6]:   month_n  = acc7(month_q, d);
							[5'd8:5'd9]:   day_n    = acc7(day_q, d);
							[5'd11:5'd12]: hour_n   = acc7(hour_q, d);
							[5'd14:5'd15]: minute_n = acc7(minute_q, d);
							default:       second_n = acc7(second_q, d);
						endcase
					end
				end
			endcase
		end
	end

	assign rec_push = accept && item.end_of_text;

	always_comb begin
		rec.ok = (pos_n == 5'(TS_LENGTH)) && !err_n &&
		         (year_n >= 14'(YEAR_MIN)) && (year_n <= 14'(YEAR_MAX)) &&
		         (month_n >= 7'd1) && (month_n <= 7'd12) &&
		         (day_n >= 7'd1) && (day_n <= 7'd31) &&
		         (hour_n <= 7'd23) && (minute_n <= 7'd59) && (second_n <= 7'd59);
		rec.yoff      = 8'(year_n - 14'(YEAR_MIN));
		rec.month_idx = 4'(month_n - 7'd1);
		rec.day       = day_n[4:0];
		rec.hour      = hour_n[4:0];
		rec.minute    = minute_n[5:0];
		rec.second    = second_n[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (item.end_of_text) begin
				pos_q    <= '0;
				err_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				pos_q    <= pos_n;
				err_q    <= err_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
			end
		end
	end

endmodule

// ----- src/iso2ep_queue.sv -----
module iso2ep_queue import iso2ep_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_data,
	output logic full,
	input  logic pop,
	output rec_t pop_data,
	output logic empty
);

	rec_t             mem_q [MQ_DEPTH];
	logic [MQ_AW-1:0] wr_q, rd_q;
	logic [MQ_AW:0]   count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == (MQ_AW+1)'(MQ_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (MQ_AW+1)'(do_push) - (MQ_AW+1)'(do_pop);
		end
	end

endmodule

// ----- src/iso2ep_back.sv -----
module iso2ep_back import iso2ep_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_empty,
	input  rec_t      rec,
	output logic      rec_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic             v_s1, v_s2, v_s3;
	logic             ok_s1, ok_s2;
	logic [15:0]      days_s1;
	logic [16:0]      tod_s1, tod_s2;
	logic [31:0]      prod_s2;
	out_item_t        res_s3;
	out_item_t        oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q, rd_q;
	logic [OQ_AW:0]   count_q;
	logic [OQ_AW+1:0] claimed;
	logic             leap, do_pop;
	logic [15:0]      days;
	logic [16:0]      tod;

	// room is reserved for every beat still in the pipe
	assign claimed = {1'b0, count_q} + (OQ_AW+2)'(v_s1) + (OQ_AW+2)'(v_s2)
	                 + (OQ_AW+2)'(v_s3);
	assign rec_pop = !rec_empty && (claimed < (OQ_AW+2)'(OQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_pop  = pop && !empty;
	assign result  = oq_q[rd_q];

	always_comb begin
		leap = (2'(rec.yoff + 8'd2) == 2'd0) && (rec.yoff != YOFF_2100);
		days = 16'({8'd0, rec.yoff} * 16'd365)
		     + {8'd0, 8'(rec.yoff + 8'd1) >> 2}
		     + {7'd0, month_start(rec.month_idx)}
		     + {15'd0, leap && (rec.month_idx >= 4'd2)}
		     + {11'd0, rec.day} - 16'd1;
		tod  = 17'({12'd0, rec.hour} * 17'd3600)
		     + 17'({11'd0, rec.minute} * 17'd60)
		     + {11'd0, rec.second};
	end

	always_ff @(posedge clk) begin
		ok_s1   <= rec.ok;
		days_s1 <= days;
		tod_s1  <= tod;
		ok_s2   <= ok_s1;
		prod_s2 <= 32'({16'd0, days_s1} * 32'd86400);
		tod_s2  <= tod_s1;
		res_s3.ok            <= ok_s2;
		res_s3.epoch_seconds <= ok_s2 ? (prod_s2 + {15'd0, tod_s2}) : 32'd0;
		if (v_s3) oq_q[wr_q] <= res_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			v_s1 <= rec_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (OQ_AW+1)'(v_s3) - (OQ_AW+1)'(do_pop);
		end
	end

endmodule

// ----- src/iso8601_timestamp_to_epoch_unit.sv -----
// Converts YYYY-MM-DDThh:mm:ss text to Unix seconds.
// Input queue side: one character per beat on item, taken when push is high
// and full is low. end_of_text marks the last character; only that beat
// produces a result. Characters past the 19th are ignored.
// Result queue side: while empty is low, result holds the oldest result
// (ok flag, epoch_seconds, zero when not ok); pop takes it.
// Throughput: while full is low, one character per cycle; one text may end every cycle.
// A result passes in order through the parse queue write, day count, multiply
// by 86400, final add and result queue.
// A 4-entry queue of parsed texts sits between the parser and the arithmetic
// pipe; the pipe only starts a text when the 8-entry result queue has room
// for it, so a stalled receiver backs up through the parse queue into full.
// Reset clears the parser state and both queues; nothing is in flight after.
module iso8601_timestamp_to_epoch_unit import iso2ep_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic accept, rec_push, rec_pop, mq_empty;
	rec_t rec_in, rec_out;

	assign accept = push && !full;

	iso2ep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	iso2ep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec_in),
		.full      (full),
		.pop       (rec_pop),
		.pop_data  (rec_out),
		.empty     (mq_empty)
	);

	iso2ep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (mq_empty),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	a_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.ok) |-> (result.epoch_seconds == 32'd0))
		else $error("failed text gives nonzero seconds");

	a_max_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.ok) |-> (result.epoch_seconds <= 32'd4133980799))
		else $error("seconds beyond end of 2100");

	a_full_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !mq_empty)
		else $error("full raised with empty parse queue");

endmodule
